>>> rtl/core/tli_pkg.sv
// shared types and constants for the table linear interpolator
// command and status structs between controller and datapath
// no dependencies
package tli_pkg;

	localparam int VAL_W = 32;
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;

	localparam logic [CNT_W-1:0] CNT_RESET = 9'd256;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic wr;         // write table entry
		logic cap;        // capture query point
		logic lo_load;    // keep current read as lower neighbor
		logic found;      // interval found, form differences
		logic mul0;       // low sample times upper distance
		logic mul1;       // high sample times lower distance
		logic add;        // sum of the two products
		logic div_start;
		logic res_zero;   // out of range result
		logic res_quot;   // interpolated result
	} tli_cmd_t;

	typedef struct packed {
		logic q_lt;       // query below read grid point
		logic q_gt;       // query above read grid point
		logic div_done;
	} tli_stat_t;

endpackage

>>> rtl/core/table_linear_interpolator.sv
// Piecewise-linear interpolation over a loaded table of ascending grid points and
// sampled values. A load (req_type 0) is taken and busy stays low;
// entry indexes not below ENTRIES are dropped. A query (req_type 1) raises busy
// and its result appears on interp_value and in_range, which hold it, while done is
// high for exactly one cycle; the receiver cannot stall it. A query that leaves the
// table at the first or the last point check gives a zero result. One that finds
// its interval checks both ends, scans the grid memory one entry per cycle, forms
// the two products and their sum, starts the bit-serial restoring divider and
// strobes the result. A query equal to the last point scans the whole used table
// and ends with zero. entry_count may only be written while busy is low.
// depends on tli_pkg, tli_ctrl, tli_datapath
module table_linear_interpolator #(
	parameter int ENTRIES = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       req_type,
	input  logic [tli_pkg::IDX_W-1:0]  entry_index,
	input  logic [tli_pkg::VAL_W-1:0]  grid_value,
	input  logic [tli_pkg::VAL_W-1:0]  sample_value,
	input  logic [tli_pkg::VAL_W-1:0]  query_point,
	input  logic                       cfg_we,
	input  logic [tli_pkg::CNT_W-1:0]  cfg_wdata,
	output logic                       done,
	output logic [tli_pkg::VAL_W-1:0]  interp_value,
	output logic                       in_range
);
	import tli_pkg::*;

	localparam int AW = $clog2(ENTRIES);

	tli_cmd_t      cmd;
	tli_stat_t     stat;
	logic [AW-1:0] raddr;

	tli_ctrl #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req_type),
		.entry_index (entry_index),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.stat        (stat),
		.cmd         (cmd),
		.raddr       (raddr),
		.busy        (busy),
		.done        (done)
	);

	tli_datapath #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.raddr        (raddr),
		.entry_index  (entry_index),
		.grid_value   (grid_value),
		.sample_value (sample_value),
		.query_point  (query_point),
		.stat         (stat),
		.interp_value (interp_value),
		.in_range     (in_range)
	);

	// a result only follows a query in flight
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a query in flight");

	a_zero_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !in_range) |-> (interp_value == '0))
		else $error("out of range result is not zero");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_QUERY) |=> busy)
		else $error("query transfer did not start the sequencer");

	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_LOAD) |=> (!busy && !done))
		else $error("load transfer disturbed the sequencer");

endmodule

>>> rtl/core/tli_div.sv
// restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle
// the quotient must fit in 32 bits; depends on tli_pkg
module tli_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [2*tli_pkg::VAL_W-1:0] num,
	input  logic [tli_pkg::VAL_W-1:0]   den,
	output logic [tli_pkg::VAL_W-1:0]   quot,
	output logic                     done
);
	import tli_pkg::*;

	logic [VAL_W-1:0] rem_q;
	logic [VAL_W-1:0] lo_q;
	logic [VAL_W-1:0] den_q;
	logic [4:0]       cnt_q;
	logic             run_q;
	logic             done_q;

	logic [VAL_W:0] shifted;
	logic [VAL_W:0] diff;
	logic           qbit;

	always_comb begin
		shifted = {rem_q, lo_q[VAL_W-1]};
		diff    = shifted - {1'b0, den_q};
		qbit    = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd31;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// upper half of the dividend must be below the divisor; the divider does not check it
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[2*VAL_W-1:VAL_W];
			lo_q  <= num[VAL_W-1:0];
			den_q <= den;
		end else if (run_q) begin
			rem_q <= qbit ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
			lo_q  <= {lo_q[VAL_W-2:0], qbit};
		end
	end

	assign quot = lo_q;
	assign done = done_q;

endmodule

>>> rtl/core/tli_datapath.sv
// datapath: grid and sample memories, neighbor registers, multiplier, divider
// depends on tli_pkg and tli_div
module tli_datapath #(
	parameter int ENTRIES = 256,
	parameter int AW = $clog2(ENTRIES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tli_pkg::tli_cmd_t          cmd,
	input  logic [AW-1:0]              raddr,
	input  logic [tli_pkg::IDX_W-1:0]  entry_index,
	input  logic [tli_pkg::VAL_W-1:0]  grid_value,
	input  logic [tli_pkg::VAL_W-1:0]  sample_value,
	input  logic [tli_pkg::VAL_W-1:0]  query_point,
	output tli_pkg::tli_stat_t         stat,
	output logic [tli_pkg::VAL_W-1:0]  interp_value,
	output logic                       in_range
);
	import tli_pkg::*;

	logic [VAL_W-1:0] grid_mem   [ENTRIES];
	logic [VAL_W-1:0] sample_mem [ENTRIES];

	logic [VAL_W-1:0]   g_rd_q, s_rd_q;
	logic [VAL_W-1:0]   q_q;
	logic [VAL_W-1:0]   lo_g_q, lo_s_q, hi_s_q;
	logic [VAL_W-1:0]   a_q, b_q, d_q;
	logic [2*VAL_W-1:0] prod_q, num_q;
	logic [VAL_W-1:0]   res_val_q;
	logic               res_ok_q;

	logic [VAL_W-1:0]   mul_x, mul_y;
	logic [2*VAL_W-1:0] mul_p;
	logic [VAL_W-1:0]   quot;
	logic               div_done;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			grid_mem[AW'(entry_index)]   <= grid_value;
			sample_mem[AW'(entry_index)] <= sample_value;
		end
	end

	always_ff @(posedge clk) begin
		g_rd_q <= grid_mem[raddr];
		s_rd_q <= sample_mem[raddr];
	end

	always_comb begin
		mul_x = cmd.mul1 ? hi_s_q : lo_s_q;
		mul_y = cmd.mul1 ? b_q : a_q;
		mul_p = (2*VAL_W)'(mul_x) * (2*VAL_W)'(mul_y);
	end

	always_ff @(posedge clk) begin
		if (cmd.cap)
			q_q <= query_point;
		if (cmd.lo_load) begin
			lo_g_q <= g_rd_q;
			lo_s_q <= s_rd_q;
		end
		if (cmd.found) begin
			a_q    <= g_rd_q - q_q;
			b_q    <= q_q - lo_g_q;
			d_q    <= g_rd_q - lo_g_q;
			hi_s_q <= s_rd_q;
		end
		if (cmd.mul0 || cmd.mul1)
			prod_q <= mul_p;
		if (cmd.mul1)
			num_q <= prod_q;
		else if (cmd.add)
			num_q <= num_q + prod_q;
		if (cmd.res_zero) begin
			res_val_q <= '0;
			res_ok_q  <= 1'b0;
		end else if (cmd.res_quot) begin
			res_val_q <= quot;
			res_ok_q  <= 1'b1;
		end
	end

	tli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (d_q),
		.quot   (quot),
		.done   (div_done)
	);

	always_comb begin
		stat.q_lt     = q_q < g_rd_q;
		stat.q_gt     = q_q > g_rd_q;
		stat.div_done = div_done;
	end

	assign interp_value = res_val_q;
	assign in_range     = res_ok_q;

endmodule

>>> rtl/core/tli_ctrl.sv
// controller: entry count register, table scan sequencer, result strobe
// depends on tli_pkg
module tli_ctrl #(
	parameter int ENTRIES = 256,
	parameter int AW = $clog2(ENTRIES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       req_type,
	input  logic [tli_pkg::IDX_W-1:0]  entry_index,
	input  logic                       cfg_we,
	input  logic [tli_pkg::CNT_W-1:0]  cfg_wdata,
	input  tli_pkg::tli_stat_t         stat,
	output tli_pkg::tli_cmd_t          cmd,
	output logic [AW-1:0]              raddr,
	output logic                       busy,
	output logic                       done
);
	import tli_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK0 = 4'd1;
	localparam logic [3:0] S_CHKL = 4'd2;
	localparam logic [3:0] S_SRCH = 4'd3;
	localparam logic [3:0] S_MUL0 = 4'd4;
	localparam logic [3:0] S_MUL1 = 4'd5;
	localparam logic [3:0] S_ADD  = 4'd6;
	localparam logic [3:0] S_DIVS = 4'd7;
	localparam logic [3:0] S_DIVW = 4'd8;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0]    idx_q, idx_d;
	logic [AW-1:0]    last;
	logic             done_q, done_d;
	logic             accept;

	always_comb begin
		if (cnt_q < 9'd2)
			last = AW'(1);
		else if (32'(cnt_q) > 32'(ENTRIES))
			last = AW'(ENTRIES - 1);
		else
			last = AW'(cnt_q - 9'd1);
	end

	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		raddr   = '0;
		state_d = state_q;
		idx_d   = idx_q;
		done_d  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_QUERY) begin
						cmd.cap = 1'b1;
						state_d = S_CHK0;
					end else if (32'(entry_index) < 32'(ENTRIES)) begin
						cmd.wr = 1'b1;
					end
				end
			end
			S_CHK0: begin
				if (stat.q_lt) begin
					cmd.res_zero = 1'b1;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.lo_load = 1'b1;
					raddr       = last;
					state_d     = S_CHKL;
				end
			end
			S_CHKL: begin
				if (stat.q_gt) begin
					cmd.res_zero = 1'b1;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					raddr   = AW'(1);
					idx_d   = AW'(1);
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				// read data holds the entry at idx_q, next address goes out now
				if (stat.q_lt) begin
					cmd.found = 1'b1;
					state_d   = S_MUL0;
				end else if (idx_q == last) begin
					cmd.res_zero = 1'b1;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.lo_load = 1'b1;
					raddr       = idx_q + AW'(1);
					idx_d       = idx_q + AW'(1);
				end
			end
			S_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d  = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_DIVS;
			end
			S_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (stat.div_done) begin
					cmd.res_quot = 1'b1;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= CNT_RESET;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			done_q  <= done_d;
			if (cfg_we)
				cnt_q <= cfg_wdata;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule
